// File: design/assert_macros.svh
// Concurrent check helpers shared by the scanner modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define ITS_ASSERT(name, prop) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("scanner check failed");

// Check on every clock edge, reset included.
`define ITS_ASSERT_ALWAYS(name, prop) \
    name: assert property (@(posedge i_clk) prop) \
        else $error("scanner check failed");

`endif

// File: design/its_pkg.sv
`timescale 1ns / 1ps

package its_pkg;

    localparam int POS_W = 16;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    typedef logic [POS_W-1:0] t_pos;
    typedef logic [PTR_W-1:0] t_ptr;
    typedef logic [CNT_W-1:0] t_cnt;

    localparam t_pos POS_MAX = '1;

    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_END  = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        K_IDENT     = 3'd0,
        K_NUMBER    = 3'd1,
        K_STRING    = 3'd2,
        K_COMMA     = 3'd3,
        K_INVALID   = 3'd4,
        K_UNTERM    = 3'd5,
        K_NL_IN_STR = 3'd6,
        K_END       = 3'd7
    } t_kind;

    typedef enum logic [9:0] {
        M_IDLE       = 10'b00_0000_0001,
        M_IDENT      = 10'b00_0000_0010,
        M_NUM_INT    = 10'b00_0000_0100,
        M_NUM_FRAC   = 10'b00_0000_1000,
        M_STRING     = 10'b00_0001_0000,
        M_SLASH      = 10'b00_0010_0000,
        M_MINUS      = 10'b00_0100_0000,
        M_LINE       = 10'b00_1000_0000,
        M_BLOCK      = 10'b01_0000_0000,
        M_BLOCK_STAR = 10'b10_0000_0000
    } t_mode;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_Z  = 8'h5A;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_Z  = 8'h7A;

    typedef struct packed {
        t_kind kind;
        t_pos  row;
        t_pos  col;
        t_pos  len;
        logic  last;
    } t_result;

    typedef struct packed {
        logic    a_valid;
        t_result a;
        logic    b_valid;
        t_result b;
    } t_emit;

    function automatic t_pos sat_inc(input t_pos x);
        return (x == POS_MAX) ? x : x + 1'b1;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= CH_LC_A && c <= CH_LC_Z) || (c >= CH_UC_A && c <= CH_UC_Z)
            || c == CH_UNDER;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= CH_0 && c <= CH_9;
    endfunction

    function automatic logic is_nl(input logic [7:0] c);
        return c == CH_LF || c == CH_CR;
    endfunction

endpackage

// File: design/its_scan_core.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module its_scan_core import its_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_go,
    input  t_op        i_opcode,
    input  logic [7:0] i_byte,
    output t_emit      o_emit
);

    t_mode   r_mode, n_mode;
    logic    r_after_cr, n_after_cr;
    t_pos    r_row, n_row;
    t_pos    r_col, n_col;
    t_pos    r_start_row, n_start_row;
    t_pos    r_start_col, n_start_col;
    t_pos    r_len, n_len;

    logic    idle_scan;
    logic    tok_v;
    t_result tok;
    logic    sec_v;
    t_result sec;

    always_comb begin
        n_mode      = r_mode;
        n_after_cr  = r_after_cr;
        n_row       = r_row;
        n_col       = r_col;
        n_start_row = r_start_row;
        n_start_col = r_start_col;
        n_len       = r_len;
        idle_scan   = 1'b0;
        tok_v       = 1'b0;
        tok         = '0;
        sec_v       = 1'b0;
        sec         = '0;

        if (i_go && i_opcode == OP_END) begin
            tok = '{kind: K_IDENT, row: r_start_row, col: r_start_col, len: r_len,
                    last: 1'b0};
            unique case (r_mode)
                M_IDENT: begin
                    tok_v = 1'b1;
                end
                M_NUM_INT, M_NUM_FRAC, M_MINUS: begin
                    tok_v    = 1'b1;
                    tok.kind = K_NUMBER;
                end
                M_STRING: begin
                    tok_v    = 1'b1;
                    tok.kind = K_UNTERM;
                end
                M_SLASH: begin
                    tok_v    = 1'b1;
                    tok.kind = K_INVALID;
                end
                default: begin
                    tok_v = 1'b0;
                end
            endcase
            sec_v       = 1'b1;
            sec         = '{kind: K_END, row: r_row, col: r_col, len: '0, last: 1'b1};
            n_mode      = M_IDLE;
            n_after_cr  = 1'b0;
            n_row       = '0;
            n_col       = '0;
            n_start_row = '0;
            n_start_col = '0;
            n_len       = '0;
        end else if (i_go && !(r_after_cr && i_byte == CH_LF)) begin
            n_after_cr = 1'b0;
            if (n_mode == M_MINUS && i_byte != CH_MINUS) begin
                n_mode = M_NUM_INT;
            end
            tok = '{kind: K_IDENT, row: r_start_row, col: r_start_col, len: r_len,
                    last: 1'b0};
            unique case (n_mode)
                M_IDENT: begin
                    if (is_alpha(i_byte) || is_digit(i_byte) || i_byte == CH_MINUS
                        || i_byte == CH_PLUS || i_byte == CH_DOT) begin
                        n_col = sat_inc(n_col);
                        n_len = sat_inc(n_len);
                    end else begin
                        tok_v     = 1'b1;
                        idle_scan = 1'b1;
                    end
                end
                M_NUM_INT, M_NUM_FRAC: begin
                    if (is_digit(i_byte)) begin
                        n_col = sat_inc(n_col);
                        n_len = sat_inc(n_len);
                    end else if (i_byte == CH_DOT && n_mode == M_NUM_INT) begin
                        n_col  = sat_inc(n_col);
                        n_len  = sat_inc(n_len);
                        n_mode = M_NUM_FRAC;
                    end else begin
                        tok_v     = 1'b1;
                        tok.kind  = K_NUMBER;
                        idle_scan = 1'b1;
                    end
                end
                M_STRING: begin
                    if (is_nl(i_byte)) begin
                        tok_v     = 1'b1;
                        tok.kind  = K_NL_IN_STR;
                        idle_scan = 1'b1;
                    end else begin
                        n_col = sat_inc(n_col);
                        n_len = sat_inc(n_len);
                        if (i_byte == CH_QUOTE) begin
                            tok_v    = 1'b1;
                            tok.kind = K_STRING;
                            tok.len  = n_len;
                            n_mode   = M_IDLE;
                        end
                    end
                end
                M_SLASH: begin
                    if (i_byte == CH_SLASH || i_byte == CH_STAR) begin
                        n_col  = sat_inc(n_col);
                        n_mode = (i_byte == CH_SLASH) ? M_LINE : M_BLOCK_STAR;
                    end else begin
                        tok_v     = 1'b1;
                        tok.kind  = K_INVALID;
                        idle_scan = 1'b1;
                    end
                end
                M_MINUS: begin
                    n_col  = sat_inc(n_col);
                    n_mode = M_LINE;
                end
                M_LINE: begin
                    if (is_nl(i_byte)) begin
                        n_row      = sat_inc(n_row);
                        n_col      = '0;
                        n_after_cr = (i_byte == CH_CR);
                        n_mode     = M_IDLE;
                    end else begin
                        n_col = sat_inc(n_col);
                    end
                end
                M_BLOCK, M_BLOCK_STAR: begin
                    if (is_nl(i_byte)) begin
                        n_row      = sat_inc(n_row);
                        n_col      = '0;
                        n_after_cr = (i_byte == CH_CR);
                        n_mode     = M_BLOCK;
                    end else begin
                        n_col = sat_inc(n_col);
                        if (n_mode == M_BLOCK_STAR && i_byte == CH_SLASH) begin
                            n_mode = M_IDLE;
                        end else begin
                            n_mode = (i_byte == CH_STAR) ? M_BLOCK_STAR : M_BLOCK;
                        end
                    end
                end
                default: begin
                    idle_scan = 1'b1;
                end
            endcase

            if (idle_scan) begin
                n_mode = M_IDLE;
                priority if (i_byte == CH_SPACE || i_byte == CH_TAB) begin
                    n_col = sat_inc(n_col);
                end else if (is_nl(i_byte)) begin
                    n_row      = sat_inc(n_row);
                    n_col      = '0;
                    n_after_cr = (i_byte == CH_CR);
                end else if (i_byte == CH_HASH) begin
                    n_col  = sat_inc(n_col);
                    n_mode = M_LINE;
                end else begin
                    n_start_row = n_row;
                    n_start_col = n_col;
                    n_len       = POS_W'(1);
                    n_col       = sat_inc(n_col);
                    priority if (i_byte == CH_SLASH) begin
                        n_mode = M_SLASH;
                    end else if (i_byte == CH_MINUS) begin
                        n_mode = M_MINUS;
                    end else if (is_alpha(i_byte)) begin
                        n_mode = M_IDENT;
                    end else if (is_digit(i_byte)) begin
                        n_mode = M_NUM_INT;
                    end else if (i_byte == CH_QUOTE) begin
                        n_mode = M_STRING;
                    end else begin
                        sec_v = 1'b1;
                        sec   = '{kind: (i_byte == CH_COMMA) ? K_COMMA : K_INVALID,
                                  row: n_start_row, col: n_start_col,
                                  len: POS_W'(1), last: 1'b1};
                    end
                end
            end
        end else if (i_go) begin
            n_after_cr = 1'b0;
        end
    end

    always_comb begin
        o_emit = '0;
        if (tok_v) begin
            o_emit.a_valid = 1'b1;
            o_emit.a       = tok;
            o_emit.a.last  = !sec_v;
            o_emit.b_valid = sec_v;
            o_emit.b       = sec;
        end else begin
            o_emit.a_valid = sec_v;
            o_emit.a       = sec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= M_IDLE;
            r_after_cr  <= 1'b0;
            r_row       <= '0;
            r_col       <= '0;
            r_start_row <= '0;
            r_start_col <= '0;
            r_len       <= '0;
        end else begin
            r_mode      <= n_mode;
            r_after_cr  <= n_after_cr;
            r_row       <= n_row;
            r_col       <= n_col;
            r_start_row <= n_start_row;
            r_start_col <= n_start_col;
            r_len       <= n_len;
        end
    end

    `ITS_ASSERT(a_end_clears, i_go && i_opcode == OP_END |=> r_mode == M_IDLE && r_row == '0 && r_col == '0 && !r_after_cr)
    `ITS_ASSERT(a_two_needs_first, o_emit.b_valid |-> o_emit.a_valid && !o_emit.a.last)
    `ITS_ASSERT(a_emit_only_on_go, !i_go |-> !o_emit.a_valid)

endmodule

// File: design/its_result_fifo.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module its_result_fifo import its_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_emit   i_push,
    input  logic    i_pop,
    output logic    o_room,
    output logic    o_valid,
    output t_result o_head
);

    t_result mem [FIFO_DEPTH];
    t_ptr    r_wr, n_wr;
    t_ptr    r_rd, n_rd;
    t_cnt    r_count, n_count;
    t_cnt    push_n;
    logic    pop_ok;

    assign pop_ok  = i_pop && (r_count != '0);
    assign push_n  = t_cnt'(i_push.a_valid) + t_cnt'(i_push.b_valid);
    assign n_wr    = r_wr + push_n[PTR_W-1:0];
    assign n_rd    = r_rd + t_ptr'(pop_ok);
    assign n_count = r_count + push_n - t_cnt'(pop_ok);
    assign o_room  = r_count <= t_cnt'(FIFO_DEPTH - 2);
    assign o_valid = r_count != '0;
    assign o_head  = mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push.a_valid) begin
            mem[r_wr] <= i_push.a;
        end
        if (i_push.b_valid) begin
            mem[r_wr + t_ptr'(1)] <= i_push.b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    `ITS_ASSERT_ALWAYS(a_count_bound, !i_rst_n || r_count <= t_cnt'(FIFO_DEPTH))
    `ITS_ASSERT(a_push_has_room, i_push.a_valid |-> r_count <= t_cnt'(FIFO_DEPTH - 2))

endmodule

// File: design/idl_token_scanner.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// channel  direction  handshake             payload
// input    in         i_valid / o_stall     i_opcode, i_data_byte
// result   out        o_valid / i_stall     o_token_kind, o_start_row, o_start_column,
//                                           o_token_length, o_last_of_run
//
// One byte per cycle while o_stall is low: a beat is registered, then scanned
// combinationally into a four-entry result queue, which registers the results.
// A beat makes zero, one or two results; the queue takes a beat only with two free slots.
// Reset is synchronous, active low; it clears position, mode and the queue.
// Output stall backs up through the queue into o_stall; nothing is lost.

module idl_token_scanner import its_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_opcode,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_token_kind,
    output logic [15:0] o_start_row,
    output logic [15:0] o_start_column,
    output logic [15:0] o_token_length,
    output logic        o_last_of_run
);

    logic       r_in_valid;
    t_op        r_in_opcode;
    logic [7:0] r_in_byte;
    logic       go;
    logic       room;
    t_emit      emit;
    t_result    head;

    assign go      = r_in_valid && room;
    assign o_stall = r_in_valid && !room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_in_valid <= 1'b1;
        end else if (go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_opcode <= t_op'(i_opcode);
            r_in_byte   <= i_data_byte;
        end
    end

    its_scan_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (go),
        .i_opcode (r_in_opcode),
        .i_byte   (r_in_byte),
        .o_emit   (emit)
    );

    its_result_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (emit),
        .i_pop   (o_valid && !i_stall),
        .o_room  (room),
        .o_valid (o_valid),
        .o_head  (head)
    );

    assign o_token_kind   = head.kind;
    assign o_start_row    = head.row;
    assign o_start_column = head.col;
    assign o_token_length = head.len;
    assign o_last_of_run  = head.last;

    `ITS_ASSERT(a_stall_needs_item, o_stall |-> r_in_valid && !go)
    `ITS_ASSERT(a_take_frees_slot, r_in_valid && !o_stall && !(i_valid) |=> !r_in_valid)

endmodule
